### design/box_filter_3x3_with_stats_unit_macros.svh
// Assertion macros used by the box filter back end.
`ifndef BOX_FILTER_3X3_WITH_STATS_UNIT_MACROS_SVH
`define BOX_FILTER_3X3_WITH_STATS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BF3S_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("box filter: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BF3S_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("box filter: next-cycle check failed");

`endif

### design/bf3s_pkg.sv
`default_nettype none

package bf3s_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int MIN_SIZE     = 3;

  localparam int PIX_W        = 8;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  localparam int WIN_ROWS     = 3;
  localparam int SUM_W        = 12;

  // floor(x / 9) == (x * 7282) >> 16 for every 3x3 sum of 8-bit pixels
  localparam int RECIP_SHIFT  = 16;
  localparam int RECIP_W      = 13;
  localparam int RECIP_NINE   = 7282;
  localparam int PROD_W       = SUM_W + RECIP_W;

  localparam int STAT_W       = 32;
  localparam int FRAC_W       = 8;
  localparam int NUM_W        = STAT_W + FRAC_W;
  localparam int DIM_W        = COL_W + ROW_W;
  localparam int DIV_STEP_W   = $clog2(NUM_W);
  localparam int MMM_W        = 16;

  localparam logic [PIX_W-1:0] MIN_INIT = 8'hFF;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QLEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [COL_W-1:0] width_m1;
    logic [ROW_W-1:0] height_m1;
  } frame_size_t;

  typedef struct packed {
    logic [SUM_W-1:0] win_sum;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } queue_entry_t;

  typedef struct packed {
    logic [QLEVEL_W-1:0] level;
    logic                empty;
  } queue_status_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [1:0] {
    BACK_LOAD,
    BACK_STAT,
    BACK_DIV
  } back_state_t;

  function automatic logic [COL_W-1:0] width_m1(input logic [WIDTH_REG_W-1:0] w);
    logic [COL_W-1:0] r;
    if (w < WIDTH_REG_W'(MIN_SIZE)) begin
      r = COL_W'(MIN_SIZE - 1);
    end else if (w > WIDTH_REG_W'(MAX_WIDTH)) begin
      r = COL_W'(MAX_WIDTH - 1);
    end else begin
      r = COL_W'(w - WIDTH_REG_W'(1));
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] height_m1(input logic [HEIGHT_REG_W-1:0] h);
    logic [ROW_W-1:0] r;
    if (h < HEIGHT_REG_W'(MIN_SIZE)) begin
      r = ROW_W'(MIN_SIZE - 1);
    end else if (h > HEIGHT_REG_W'(HEIGHT_LIMIT)) begin
      r = ROW_W'(HEIGHT_LIMIT - 1);
    end else begin
      r = ROW_W'(h - HEIGHT_REG_W'(1));
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/bf3s_queue.sv
`default_nettype none

module bf3s_queue (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      push,
  input  bf3s_pkg::queue_entry_t   din,
  input  wire                      pop,
  output bf3s_pkg::queue_entry_t   dout,
  output bf3s_pkg::queue_status_t  status
);
  import bf3s_pkg::*;

  queue_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QLEVEL_W-1:0] level;
  logic                do_pop;

  assign do_pop       = pop && (level != '0);
  assign dout         = slots[rd_ptr];
  assign status.level = level;
  assign status.empty = (level == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !do_pop) begin
        level <= level + QLEVEL_W'(1);
      end else if (!push && do_pop) begin
        level <= level - QLEVEL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

### design/bf3s_front.sv
`default_nettype none

module bf3s_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      push,
  input  wire  [7:0]               pixel,
  output logic                     full,
  input  bf3s_pkg::frame_size_t    size,
  input  bf3s_pkg::queue_status_t  qstat,
  output logic                     q_push,
  output bf3s_pkg::queue_entry_t   q_entry
);
  import bf3s_pkg::*;

  logic [PIX_W-1:0]    line_a [MAX_WIDTH];
  logic [PIX_W-1:0]    line_b [MAX_WIDTH];
  logic [PIX_W-1:0]    up1;
  logic [PIX_W-1:0]    up2;

  logic [COL_W-1:0]    col_count;
  logic [COL_W-1:0]    col_count_next;
  logic [ROW_W-1:0]    row_count;
  logic [ROW_W-1:0]    row_count_next;

  logic                accept;
  logic                end_row;
  logic                end_frame;
  logic                emit;
  logic [QLEVEL_W-1:0] committed;

  logic                s_take;
  logic                s_emit;
  logic                s_last;
  logic [COL_W-1:0]    s_col;
  logic [ROW_W-1:0]    s_row;
  logic [PIX_W-1:0]    s_pixel;

  logic [PIX_W-1:0]    win_mid   [WIN_ROWS];
  logic [PIX_W-1:0]    win_right [WIN_ROWS];
  logic [SUM_W-1:0]    win_sum;

  // count the word still in flight toward the queue
  assign committed = qstat.level + QLEVEL_W'(s_emit);
  assign full      = (committed >= QLEVEL_W'(QUEUE_DEPTH));
  assign accept    = push && !full;

  assign end_row   = (col_count >= size.width_m1);
  assign end_frame = (row_count >= size.height_m1);
  assign emit      = (row_count >= ROW_W'(2)) && (col_count >= COL_W'(2));

  always_comb begin
    col_count_next = col_count;
    row_count_next = row_count;
    if (accept) begin
      if (end_row) begin
        col_count_next = '0;
        row_count_next = end_frame ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count_next = col_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s_take    <= 1'b0;
      s_emit    <= 1'b0;
      s_last    <= 1'b0;
    end else begin
      col_count <= col_count_next;
      row_count <= row_count_next;
      s_take    <= accept;
      s_emit    <= accept && emit;
      s_last    <= accept && emit && end_row && end_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_col   <= col_count;
      s_row   <= row_count;
      s_pixel <= pixel;
    end
  end

  // line stores: read the next column ahead, write back the current one
  always_ff @(posedge clk) begin
    if (s_take) begin
      line_a[s_col] <= s_pixel;
      line_b[s_col] <= up1;
    end
    up1 <= line_a[col_count];
    up2 <= line_b[col_count];
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      for (int k = 0; k < WIN_ROWS; k++) begin
        win_mid[k] <= win_right[k];
      end
      win_right[0] <= up2;
      win_right[1] <= up1;
      win_right[2] <= s_pixel;
    end
  end

  always_comb begin
    win_sum = SUM_W'(up2) + SUM_W'(up1) + SUM_W'(s_pixel);
    for (int k = 0; k < WIN_ROWS; k++) begin
      win_sum = win_sum + SUM_W'(win_mid[k]) + SUM_W'(win_right[k]);
    end
  end

  assign q_push          = s_emit;
  assign q_entry.win_sum = win_sum;
  assign q_entry.row     = s_row - ROW_W'(1);
  assign q_entry.col     = s_col - COL_W'(1);
  assign q_entry.last    = s_last;

endmodule

`default_nettype wire

### design/bf3s_div.sv
`default_nettype none

module bf3s_div (
  input  wire                  clk,
  input  wire                  rst,
  input  bf3s_pkg::div_req_t   req,
  output bf3s_pkg::div_rsp_t   rsp
);
  import bf3s_pkg::*;

  logic                  busy;
  logic [DIV_STEP_W-1:0] step;
  logic [DIM_W-1:0]      rem;
  logic [DIM_W-1:0]      divisor;
  logic [NUM_W-1:0]      work;
  logic [DIM_W:0]        trial;
  logic                  fits;
  logic [DIM_W:0]        trial_sub;

  // restoring division, one quotient bit per cycle
  assign trial     = {rem, work[NUM_W-1]};
  assign fits      = (trial >= {1'b0, divisor});
  assign trial_sub = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + DIV_STEP_W'(1);
      if (step == DIV_STEP_W'(NUM_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      work    <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem  <= fits ? trial_sub[DIM_W-1:0] : trial[DIM_W-1:0];
      work <= {work[NUM_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.quotient = work;

endmodule

`default_nettype wire

### design/bf3s_back.sv
`default_nettype none

`include "box_filter_3x3_with_stats_unit_macros.svh"

module bf3s_back (
  input  wire                      clk,
  input  wire                      rst,
  input  bf3s_pkg::frame_size_t    size,
  input  bf3s_pkg::queue_entry_t   q_entry,
  input  bf3s_pkg::queue_status_t  qstat,
  output logic                     q_pop,
  output bf3s_pkg::div_req_t       div_req,
  input  bf3s_pkg::div_rsp_t       div_rsp,
  input  wire                      pop,
  output logic                     empty,
  output logic [11:0]              out_row,
  output logic [9:0]               out_col,
  output logic [7:0]               filtered,
  output logic                     frame_done,
  output logic [7:0]               frame_minimum,
  output logic [15:0]              mean_minus_min
);
  import bf3s_pkg::*;

  back_state_t       state;
  back_state_t       state_next;

  logic              take;
  logic              load_plain;
  logic              load_final;
  logic              stat_update;
  logic              stat_clear;
  logic              out_valid;

  logic [PROD_W-1:0] recip_prod;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic              cur_last;
  logic [PIX_W-1:0]  cur_filt;

  logic [STAT_W-1:0] running_sum;
  logic [PIX_W-1:0]  running_min;
  logic [STAT_W-1:0] sum_new;
  logic [PIX_W-1:0]  min_new;
  logic [PIX_W-1:0]  hold_min;
  logic [DIM_W-1:0]  dim;

  logic [NUM_W-1:0]  min_fx;
  logic [NUM_W-1:0]  diff_full;
  logic [MMM_W-1:0]  diff_sat;

  assign take = (state == BACK_LOAD) && !qstat.empty && (!out_valid || pop);

  assign recip_prod = PROD_W'(q_entry.win_sum) * PROD_W'(RECIP_NINE);

  assign sum_new = running_sum + STAT_W'(cur_filt);
  assign min_new = (cur_filt < running_min) ? cur_filt : running_min;
  assign dim     = DIM_W'(size.width_m1 - COL_W'(1)) * DIM_W'(size.height_m1 - ROW_W'(1));

  assign min_fx    = NUM_W'({hold_min, {FRAC_W{1'b0}}});
  assign diff_full = (div_rsp.quotient > min_fx) ? div_rsp.quotient - min_fx : '0;
  assign diff_sat  = (|diff_full[NUM_W-1:MMM_W]) ? '1 : diff_full[MMM_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      BACK_LOAD: begin
        if (take) state_next = BACK_STAT;
      end
      BACK_STAT: begin
        state_next = cur_last ? BACK_DIV : BACK_LOAD;
      end
      BACK_DIV: begin
        if (!div_rsp.busy) state_next = BACK_LOAD;
      end
      default: begin
        state_next = BACK_LOAD;
      end
    endcase
  end

  always_comb begin
    q_pop            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {sum_new, {FRAC_W{1'b0}}};
    div_req.divisor  = dim;
    load_plain       = 1'b0;
    load_final       = 1'b0;
    stat_update      = 1'b0;
    stat_clear       = 1'b0;
    unique case (state)
      BACK_LOAD: begin
        q_pop = take;
      end
      BACK_STAT: begin
        if (cur_last) begin
          div_req.start = 1'b1;
          stat_clear    = 1'b1;
        end else begin
          load_plain  = 1'b1;
          stat_update = 1'b1;
        end
      end
      BACK_DIV: begin
        load_final = !div_rsp.busy;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= BACK_LOAD;
      out_valid   <= 1'b0;
      running_sum <= '0;
      running_min <= MIN_INIT;
    end else begin
      state <= state_next;
      if (load_plain || load_final) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (stat_clear) begin
        running_sum <= '0;
        running_min <= MIN_INIT;
      end else if (stat_update) begin
        running_sum <= sum_new;
        running_min <= min_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur_row  <= q_entry.row;
      cur_col  <= q_entry.col;
      cur_last <= q_entry.last;
      cur_filt <= recip_prod[RECIP_SHIFT +: PIX_W];
    end
    if (stat_clear) begin
      hold_min <= min_new;
    end
    if (load_plain || load_final) begin
      out_row  <= cur_row;
      out_col  <= cur_col;
      filtered <= cur_filt;
    end
    if (load_plain) begin
      frame_done     <= 1'b0;
      frame_minimum  <= '0;
      mean_minus_min <= '0;
    end else if (load_final) begin
      frame_done     <= 1'b1;
      frame_minimum  <= hold_min;
      mean_minus_min <= diff_sat;
    end
  end

  assign empty = !out_valid;

  `BF3S_ASSERT_NEXT(a_take_then_stat, clk, rst, q_pop, state == BACK_STAT)
  `BF3S_ASSERT_IMPLY(a_load_into_free_slot, clk, rst, load_plain || load_final, !out_valid)
  `BF3S_ASSERT_NEXT(a_div_starts_busy, clk, rst, div_req.start, div_rsp.busy && state == BACK_DIV)

endmodule

`default_nettype wire

### design/box_filter_3x3_with_stats_unit.sv
`default_nettype none

// 3x3 box filter with frame statistics. Pixels enter in raster order through
// push/full, one word per clock when the result side keeps up; each interior
// pixel yields one result word (row, column, floor(sum/9)) through empty/pop,
// border pixels yield none. The front takes one pixel per cycle while not
// full (two line stores with a registered read, a two-column window register
// and a 9-input adder); a four-word queue separates it from the back, which
// finishes one result word before taking the next (reciprocal multiply, then
// statistics update and output load). The last interior pixel of a frame
// carries frame_done, the frame minimum and mean minus minimum with 8
// fractional bits; its word is loaded once the 40-step restoring divider,
// one quotient bit per cycle, has finished. frame_width (register 0) and
// frame_height (register 1) are written via cfg_write/cfg_index/cfg_data;
// the user must write them only while the block is idle, which the block
// does not enforce itself. Values outside 3..1024 and 3..4096 are clamped.
// Line store contents are undefined after reset and need no clearing.

module box_filter_3x3_with_stats_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  output logic        full,
  input  wire  [7:0]  pixel,
  output logic        empty,
  input  wire         pop,
  output logic [11:0] out_row,
  output logic [9:0]  out_col,
  output logic [7:0]  filtered,
  output logic        frame_done,
  output logic [7:0]  frame_minimum,
  output logic [15:0] mean_minus_min,
  input  wire         cfg_write,
  input  wire  [0:0]  cfg_index,
  input  wire  [12:0] cfg_data
);
  import bf3s_pkg::*;

  logic [WIDTH_REG_W-1:0]  frame_width;
  logic [HEIGHT_REG_W-1:0] frame_height;
  frame_size_t             size;

  logic                    q_push;
  logic                    q_pop;
  queue_entry_t            q_in;
  queue_entry_t            q_head;
  queue_status_t           qstat;
  div_req_t                div_req;
  div_rsp_t                div_rsp;

  // configuration registers, write only
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_REG_W'(640);
      frame_height <= HEIGHT_REG_W'(480);
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp once here; front and back both work from width-1 and height-1
  assign size.width_m1  = width_m1(frame_width);
  assign size.height_m1 = height_m1(frame_height);

  // front: counters, line stores, window and neighborhood sum
  bf3s_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .pixel   (pixel),
    .full    (full),
    .size    (size),
    .qstat   (qstat),
    .q_push  (q_push),
    .q_entry (q_in)
  );

  // hold interior sums until the back can take them
  bf3s_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .din    (q_in),
    .pop    (q_pop),
    .dout   (q_head),
    .status (qstat)
  );

  // end-of-frame mean: one quotient bit per cycle
  bf3s_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // back: divide by nine, track statistics, drive the result word
  bf3s_back u_back (
    .clk            (clk),
    .rst            (rst),
    .size           (size),
    .q_entry        (q_head),
    .qstat          (qstat),
    .q_pop          (q_pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .pop            (pop),
    .empty          (empty),
    .out_row        (out_row),
    .out_col        (out_col),
    .filtered       (filtered),
    .frame_done     (frame_done),
    .frame_minimum  (frame_minimum),
    .mean_minus_min (mean_minus_min)
  );

endmodule

`default_nettype wire
